### hdl/rmpf_pkg.sv
// Package for the random melt pixel filter.
// Holds item types, register indexes, sizes and the row width helper.
// No dependencies.
package rmpf_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = COL_W + 1;
    localparam int PIXEL_W   = 64;
    localparam int PROB_W    = 8;
    localparam int THR_W     = PROB_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_PROB_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_SAME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_RIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROB_KEEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 3'd4;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_in;
        logic [PROB_W-1:0]  rand_pick;
        logic [PROB_W-1:0]  rand_keep;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               row_end;
        logic               last;
    } out_item_t;

    // One filter operation on one column, handed from issue to compute.
    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [PIXEL_W-1:0] px;
        logic [PROB_W-1:0]  pick;
        logic [PROB_W-1:0]  keep;
        logic               first;
        logic               at_edge;
        logic [PIXEL_W-1:0] next_first;
        logic               row_end;
        logic               last;
    } op_t;

    // Zero acts as one, anything past the line buffer acts as its size.
    function automatic logic [WIDTH_W-1:0] eff_width(input logic [CFG_DAT_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        if (w == '0)
            r = WIDTH_W'(1);
        else if (w > CFG_DAT_W'(MAX_WIDTH))
            r = WIDTH_W'(MAX_WIDTH);
        else
            r = WIDTH_W'(w);
        return r;
    endfunction

endpackage

### hdl/random_melt_pixel_filter.sv
// Random melt pixel filter, top level.
// Depends on rmpf_pkg and rmpf_ram (previous-row line buffer).
//
// Ops: an issued filter op is registered into s1_op_reg, then its result into out_item_reg;
//   a pixel's op issues when the next pixel of its row arrives, or with the row's last pixel.
// Throughput: 1 item per cycle while the output is not stalled; the last item of a row wider than one pixel is
//   held for a second op, since each result is one read-modify-write through the single write port.
// Reset: control, configuration and window registers are reset; the line buffer is not
//   cleared and needs no clearing pass (the first row of a frame never reads it).
module random_melt_pixel_filter
    import rmpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  in_item_t             item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output out_item_t            result,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    // configuration
    logic [PROB_W-1:0]    prob_left_reg, prob_same_reg, prob_right_reg, prob_keep_reg;
    logic [CFG_DAT_W-1:0] row_width_reg;

    // issue side
    logic [COL_W-1:0]   col_reg;
    logic               first_reg;
    logic               split_reg;
    logic [PIXEL_W-1:0] pend_px_reg;
    logic [PROB_W-1:0]  pend_pick_reg, pend_keep_reg;

    // compute side
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic               fwd_a_reg, fwd_b_reg;
    logic [PIXEL_W-1:0] fwd_data_reg;
    logic [PIXEL_W-1:0] window_left_reg;

    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic [WIDTH_W-1:0] w_eff;
    logic [COL_W-1:0]   c_eff;
    logic               first_eff;
    logic               has_a, has_b, sel_b, need_issue;
    logic               adv, issue_fire, accept, s1_fire;
    op_t                iss_op;
    logic [COL_W-1:0]   rd_addr_b;
    logic [PIXEL_W-1:0] rdata_a, rdata_b;
    logic [PIXEL_W-1:0] mem_a, mem_b, up, right, left, res, kept;
    logic [THR_W-1:0]   t1, t2, t3, pick_ext;

    // ---------------- issue ----------------
    assign w_eff     = eff_width(row_width_reg);
    assign c_eff     = item.frame_start ? '0 : col_reg;
    assign first_eff = item.frame_start | first_reg;
    assign has_a     = (c_eff != '0);
    assign has_b     = ({1'b0, c_eff} + WIDTH_W'(1)) >= w_eff;
    assign sel_b     = has_b && (!has_a || split_reg);
    assign need_issue = has_a || has_b;

    assign adv        = !s1_valid_reg || !out_valid_reg || result_ready;
    assign s1_fire    = s1_valid_reg && adv;
    assign item_ready = (!need_issue || adv) && !(has_a && has_b && !split_reg);
    assign accept     = item_valid && item_ready;
    assign issue_fire = item_valid && need_issue && adv;

    always_comb
    begin
        iss_op.first      = first_eff;
        iss_op.next_first = item.pixel_in;
        if (sel_b)
        begin
            iss_op.col     = c_eff;
            iss_op.px      = item.pixel_in;
            iss_op.pick    = item.rand_pick;
            iss_op.keep    = item.rand_keep;
            iss_op.at_edge = 1'b1;
            iss_op.row_end = 1'b1;
            iss_op.last    = 1'b1;
        end
        else
        begin
            iss_op.col     = c_eff - COL_W'(1);
            iss_op.px      = pend_px_reg;
            iss_op.pick    = pend_pick_reg;
            iss_op.keep    = pend_keep_reg;
            iss_op.at_edge = {1'b0, c_eff} >= w_eff;
            iss_op.row_end = 1'b0;
            iss_op.last    = !has_b;
        end
    end

    assign rd_addr_b = iss_op.col + COL_W'(1);

    // ---------------- compute ----------------
    assign mem_a = fwd_a_reg ? fwd_data_reg : rdata_a;
    assign mem_b = fwd_b_reg ? fwd_data_reg : rdata_b;

    assign t1       = THR_W'(prob_left_reg);
    assign t2       = t1 + THR_W'(prob_same_reg);
    assign t3       = t2 + THR_W'(prob_right_reg);
    assign pick_ext = THR_W'(s1_op_reg.pick);

    always_comb
    begin
        up = s1_op_reg.first ? s1_op_reg.px : mem_a;
        if (s1_op_reg.at_edge)
            right = up;
        else
            right = s1_op_reg.first ? s1_op_reg.next_first : mem_b;
        left = (s1_op_reg.col == '0) ? up : window_left_reg;

        res  = s1_op_reg.px;
        kept = s1_op_reg.px;
        if (pick_ext < t3)
        begin
            if (pick_ext < t1)
                res = left;
            else if (pick_ext < t2)
                res = up;
            else
                res = right;
            if (s1_op_reg.keep < prob_keep_reg)
                kept = res;
        end
    end

    rmpf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .wen     (s1_fire),
        .waddr   (s1_op_reg.col),
        .wdata   (kept),
        .ren     (issue_fire),
        .raddr_a (iss_op.col),
        .raddr_b (rd_addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_left_reg   <= '0;
            prob_same_reg   <= '0;
            prob_right_reg  <= '0;
            prob_keep_reg   <= '0;
            row_width_reg   <= CFG_DAT_W'(1);
            col_reg         <= '0;
            first_reg       <= 1'b1;
            split_reg       <= 1'b0;
            s1_valid_reg    <= 1'b0;
            fwd_a_reg       <= 1'b0;
            fwd_b_reg       <= 1'b0;
            window_left_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_addr)
                    REG_PROB_LEFT:  prob_left_reg  <= cfg_wdata[PROB_W-1:0];
                    REG_PROB_SAME:  prob_same_reg  <= cfg_wdata[PROB_W-1:0];
                    REG_PROB_RIGHT: prob_right_reg <= cfg_wdata[PROB_W-1:0];
                    REG_PROB_KEEP:  prob_keep_reg  <= cfg_wdata[PROB_W-1:0];
                    REG_ROW_WIDTH:  row_width_reg  <= cfg_wdata;
                    default:        ;
                endcase
            end

            // hold the item for a second op when its row ends with a pending pixel
            if (accept)
                split_reg <= 1'b0;
            else if (item_valid && has_a && has_b && adv && !split_reg)
                split_reg <= 1'b1;

            if (accept)
            begin
                if (has_b)
                begin
                    col_reg   <= '0;
                    first_reg <= 1'b0;
                end
                else
                begin
                    col_reg   <= c_eff + COL_W'(1);
                    first_reg <= first_eff;
                end
            end

            if (adv)
            begin
                s1_valid_reg <= issue_fire;
            end
            if (issue_fire)
            begin
                // catch the write that lands on the same edge as this read
                fwd_a_reg <= s1_fire && (s1_op_reg.col == iss_op.col);
                fwd_b_reg <= s1_fire && (s1_op_reg.col == rd_addr_b);
            end

            if (s1_fire)
            begin
                window_left_reg <= up;
                out_valid_reg   <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !has_b)
        begin
            pend_px_reg   <= item.pixel_in;
            pend_pick_reg <= item.rand_pick;
            pend_keep_reg <= item.rand_keep;
        end
        if (issue_fire)
        begin
            s1_op_reg <= iss_op;
        end
        if (s1_fire)
        begin
            fwd_data_reg           <= kept;
            out_item_reg.pixel_out <= res;
            out_item_reg.row_end   <= s1_op_reg.row_end;
            out_item_reg.last      <= s1_op_reg.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

### hdl/rmpf_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read.
// Read during write to the same address returns the old data.
// No dependencies.
module rmpf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### hdl/rmpf_checker.sv
// Port-level checks for the random melt pixel filter.
// Depends on rmpf_pkg; bound to random_melt_pixel_filter below.
module rmpf_checker
    import rmpf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_ready,
    input out_item_t result
);

    // a stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // the end of a row is always the final result of its item
    a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.row_end |-> result.last)
        else $error("row end without last");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge clk)
        $past(!rst_n) |-> !result_valid)
        else $error("result offered out of reset");

    // the first of a pair is never the end of a row, so a non-last result precedes one
    a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> !result.row_end)
        else $error("first of a pair marked as row end");

endmodule

bind random_melt_pixel_filter rmpf_checker u_rmpf_checker (.*);
